[design/zcpc_pkg.sv]
// Package for the ZipCrypto password checker.
// Holds the item types, the key constants and the key update functions.
// No dependencies.
`default_nettype none

package zcpc_pkg;

  typedef logic [31:0] key_t;

  // The three keys of one key set
  typedef struct packed {
    key_t k0;
    key_t k1;
    key_t k2;
  } keyset_t;

  // Kind of item, decided in the front part
  typedef enum logic [1:0] {
    OP_PW_CONT   = 2'd0,
    OP_PW_START  = 2'd1,
    OP_HDR_CONT  = 2'd2,
    OP_HDR_START = 2'd3
  } op_t;

  // Item as it waits in the queue between the front and back parts
  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic       last_flag;
    logic       last_file;
    logic [7:0] target_check;
    logic [7:0] pre_check;
  } item_t;

  // Back part sequencer states
  typedef enum logic {
    ST_FETCH  = 1'b0,
    ST_UPDATE = 1'b1
  } state_t;

  localparam key_t KEY_INIT0 = 32'h1234_5678;
  localparam key_t KEY_INIT1 = 32'h2345_6789;
  localparam key_t KEY_INIT2 = 32'h3456_7890;
  localparam key_t LCG_MULT  = 32'd134775813;
  localparam key_t CRC_POLY  = 32'hEDB8_8320;

  localparam keyset_t KEYS_INIT = '{k0: KEY_INIT0, k1: KEY_INIT1, k2: KEY_INIT2};

  // Reflected CRC-32 step for one byte.
  function automatic key_t crc_byte(input key_t c, input logic [7:0] b);
    key_t v;
    v = {24'd0, c[7:0] ^ b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return (c >> 8) ^ v;
  endfunction

  // Keystream byte from key 2.
  function automatic logic [7:0] stream_byte(input key_t k2);
    logic [15:0] t;
    logic [31:0] p;
    t = k2[15:0] | 16'h0002;
    p = 32'(t) * 32'(t ^ 16'h0001);
    return p[15:8];
  endfunction

  // One key update with byte p.
  function automatic keyset_t advance_keys(input keyset_t k, input logic [7:0] p);
    keyset_t n;
    n.k0 = crc_byte(k.k0, p);
    n.k1 = (k.k1 + {24'd0, n.k0[7:0]}) * LCG_MULT + 32'd1;
    n.k2 = crc_byte(k.k2, n.k1[31:24]);
    return n;
  endfunction

endpackage

`default_nettype wire

[design/zcpc_in_if.sv]
// Input channel of the ZipCrypto password checker: valid, ready and one item.
// Depends on nothing but plain logic types.
`default_nettype none

interface zcpc_in_if;

  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;
  logic       first_flag;
  logic       last_flag;
  logic       last_file;
  logic [7:0] target_check;
  logic [7:0] pre_check;

  modport source (
    output valid, cmd, data_byte, first_flag, last_flag, last_file,
           target_check, pre_check,
    input  ready
  );

  modport sink (
    input  valid, cmd, data_byte, first_flag, last_flag, last_file,
           target_check, pre_check,
    output ready
  );

endinterface

`default_nettype wire

[design/zcpc_out_if.sv]
// Result channel of the ZipCrypto password checker: valid, ready and one item.
// Depends on nothing but plain logic types.
`default_nettype none

interface zcpc_out_if;

  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;
  logic       header_done;
  logic       target_match;
  logic       pre_match;
  logic       all_files_match;

  modport source (
    output valid, plain_byte, header_done, target_match, pre_match, all_files_match,
    input  ready
  );

  modport sink (
    input  valid, plain_byte, header_done, target_match, pre_match, all_files_match,
    output ready
  );

endinterface

`default_nettype wire

[design/zcpc_front.sv]
// Front part: accepts input items, classifies them and queues them.
// Depends on zcpc_pkg and zcpc_in_if.
`default_nettype none

module zcpc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  zcpc_in_if.sink            request,
  output zcpc_pkg::item_t    q_item,
  output logic               q_valid,
  input  wire logic          q_ready
);

  import zcpc_pkg::*;

  localparam int unsigned QDEPTH = 2;

  item_t      entries [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      new_item;
  logic       push;
  logic       pop;

  // Classify the incoming item by command and first flag.
  always_comb begin
    new_item.data_byte    = request.data_byte;
    new_item.last_flag    = request.last_flag;
    new_item.last_file    = request.last_file;
    new_item.target_check = request.target_check;
    new_item.pre_check    = request.pre_check;
    unique case ({request.cmd, request.first_flag})
      2'b00:   new_item.op = OP_PW_CONT;
      2'b01:   new_item.op = OP_PW_START;
      2'b10:   new_item.op = OP_HDR_CONT;
      default: new_item.op = OP_HDR_START;
    endcase
  end

  // Queue handshakes.
  assign request.ready = (count != 2'(QDEPTH));
  assign q_valid       = (count != 2'd0);
  assign q_item        = entries[rd_ptr];
  assign push          = request.valid && request.ready;
  assign pop           = q_valid && q_ready;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= new_item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/zcpc_back.sv]
// Back part: runs the key updates, decrypts header bytes, keeps the match flag
// and holds the result register. Depends on zcpc_pkg and zcpc_out_if.
`default_nettype none

module zcpc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire zcpc_pkg::item_t q_item,
  input  wire logic          q_valid,
  output logic               q_ready,
  zcpc_out_if.source         result
);

  import zcpc_pkg::*;

  state_t     state;
  state_t     state_next;
  item_t      cur;
  keyset_t    pw_keys;
  keyset_t    wk_keys;
  logic [7:0] ks;
  logic [7:0] prev_plain;
  logic       all_flag;

  logic       cur_hdr;
  logic       finish;
  logic [7:0] plain;
  logic [7:0] upd_byte;
  keyset_t    upd_keys;
  key_t       src_k2;
  logic       tmatch;
  logic       pmatch;
  logic       all_now;

  logic       out_valid;
  logic [7:0] out_plain;
  logic       out_done;
  logic       out_tmatch;
  logic       out_pmatch;
  logic       out_all;

  assign cur_hdr = (cur.op == OP_HDR_CONT) || (cur.op == OP_HDR_START);

  // Next state of the two-step sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_FETCH:  if (q_valid) state_next = ST_UPDATE;
      ST_UPDATE: if (finish)  state_next = ST_FETCH;
      default:   state_next = ST_FETCH;
    endcase
  end

  // Sequencer outputs: a header item waits while the result register is full and not being taken.
  always_comb begin
    q_ready = 1'b0;
    finish  = 1'b0;
    unique case (state)
      ST_FETCH:  q_ready = 1'b1;
      ST_UPDATE: finish  = !cur_hdr || !out_valid || result.ready;
      default: begin
        q_ready = 1'b0;
        finish  = 1'b0;
      end
    endcase
  end

  // Keystream source: a new header starts from the password keys.
  assign src_k2 = (q_item.op == OP_HDR_START) ? pw_keys.k2 : wk_keys.k2;

  // Decrypt, update the selected key set and compare check bytes.
  always_comb begin
    plain    = cur.data_byte ^ ks;
    upd_byte = cur_hdr ? plain : cur.data_byte;
    upd_keys = advance_keys(cur_hdr ? wk_keys : pw_keys, upd_byte);
    tmatch   = cur.last_flag && (plain == cur.target_check);
    pmatch   = cur.last_flag && (prev_plain == cur.pre_check);
    all_now  = all_flag && (!cur.last_flag || tmatch);
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FETCH;
    end else begin
      state <= state_next;
    end
  end

  // Current item and keystream byte, taken when the item leaves the queue.
  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      cur <= q_item;
      ks  <= stream_byte(src_k2);
    end
  end

  // Key sets, previous plaintext and the all-files flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      pw_keys    <= KEYS_INIT;
      wk_keys    <= '0;
      prev_plain <= 8'd0;
      all_flag   <= 1'b1;
    end else if (state == ST_FETCH) begin
      if (q_valid) begin
        if (q_item.op == OP_PW_START) begin
          pw_keys  <= KEYS_INIT;
          all_flag <= 1'b1;
        end
        if (q_item.op == OP_HDR_START) begin
          wk_keys <= pw_keys;
        end
      end
    end else if (finish) begin
      if (cur_hdr) begin
        wk_keys    <= upd_keys;
        prev_plain <= plain;
        all_flag   <= (cur.last_flag && cur.last_file) ? 1'b1 : all_now;
      end else begin
        pw_keys <= upd_keys;
      end
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish && cur_hdr) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (finish && cur_hdr) begin
      out_plain  <= plain;
      out_done   <= cur.last_flag;
      out_tmatch <= tmatch;
      out_pmatch <= pmatch;
      out_all    <= all_now;
    end
  end

  assign result.valid           = out_valid;
  assign result.plain_byte      = out_plain;
  assign result.header_done     = out_done;
  assign result.target_match    = out_tmatch;
  assign result.pre_match       = out_pmatch;
  assign result.all_files_match = out_all;

endmodule

`default_nettype wire

[design/zipcrypto_password_checker_unit.sv]
// ZipCrypto password checker: tests one password against encryption headers.
// The back part takes a new item only after the fetch and key update steps for the last one.
// A header item's result is registered when its key update step finishes.
// A two-item queue lets input be accepted while a result waits to be taken.
// Reset loads the password keys with the fixed constants, clears working keys
// and previous plaintext, sets the all-files flag and empties queue and output.
`default_nettype none

module zipcrypto_password_checker_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  zcpc_in_if.sink    request,
  zcpc_out_if.source result
);

  import zcpc_pkg::*;

  item_t q_item;
  logic  q_valid;
  logic  q_ready;

  // Accept, classify and queue items.
  zcpc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  // Key updates, decryption and result register.
  zcpc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .result  (result)
  );

endmodule

`default_nettype wire

[dv/zipcrypto_password_checker_unit_tb.sv]
// Testbench for the ZipCrypto password checker unit.
// Needs zcpc_pkg and the zcpc_in_if / zcpc_out_if channel interfaces.
`timescale 1ns / 1ps

module zipcrypto_password_checker_unit_tb;
  import zcpc_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 600;
  localparam int TAIL_CYCLES  = 20;
  localparam int IDLE_PCT     = 21;
  localparam int REPORT_MAX   = 10;

  localparam logic CMD_PASSWORD = 1'b0;
  localparam logic CMD_HEADER   = 1'b1;

  // One input item as driven onto the request channel.
  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic       first_flag;
    logic       last_flag;
    logic       last_file;
    logic [7:0] target_check;
    logic [7:0] pre_check;
  } check_req_t;

  // One result item as seen on the result channel.
  typedef struct packed {
    logic [7:0] plain_byte;
    logic       header_done;
    logic       target_match;
    logic       pre_match;
    logic       all_files_match;
  } check_res_t;

  // Tracks the key state of the checker and the decrypted header bytes it owes.
  class header_check_scoreboard;
    keyset_t    pw_keys;
    keyset_t    hdr_keys;
    logic [7:0] last_plain;
    bit         all_ok;
    check_res_t owed_q[$];
    int         mismatches;

    function new();
      pw_keys    = KEYS_INIT;
      hdr_keys   = '0;
      last_plain = 8'h00;
      all_ok     = 1'b1;
      mismatches = 0;
    endfunction

    // Bitwise form of the reflected CRC-32 byte step.
    function key_t crc_step(input key_t c, input logic [7:0] b);
      key_t r;
      r = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
        r = {1'b0, r[31:1]} ^ (r[0] ? CRC_POLY : 32'd0);
      end
      return r;
    endfunction

    function keyset_t roll_keys(input keyset_t k, input logic [7:0] p);
      keyset_t n;
      n.k0 = crc_step(k.k0, p);
      n.k1 = (k.k1 + key_t'(n.k0[7:0])) * LCG_MULT + 32'd1;
      n.k2 = crc_step(k.k2, n.k1[31:24]);
      return n;
    endfunction

    function logic [7:0] stream_of(input key_t k2);
      logic [15:0] t;
      logic [31:0] prod;
      t    = k2[15:0] | 16'h0002;
      prod = {16'd0, t} * {16'd0, t ^ 16'h0001};
      return prod[15:8];
    endfunction

    // Keystream byte that the next header item would use.
    function logic [7:0] next_stream(input bit starts_file);
      return stream_of(starts_file ? pw_keys.k2 : hdr_keys.k2);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Advances the state with an accepted item and queues its result.
    function void note_item(input check_req_t r);
      check_res_t e;
      logic [7:0] plain;
      if (r.cmd == CMD_PASSWORD) begin
        if (r.first_flag) begin
          pw_keys = KEYS_INIT;
          all_ok  = 1'b1;
        end
        pw_keys = roll_keys(pw_keys, r.data_byte);
      end else begin
        if (r.first_flag) hdr_keys = pw_keys;
        plain    = r.data_byte ^ stream_of(hdr_keys.k2);
        hdr_keys = roll_keys(hdr_keys, plain);
        e = '0;
        e.plain_byte  = plain;
        e.header_done = r.last_flag;
        if (r.last_flag) begin
          e.target_match = (plain == r.target_check);
          e.pre_match    = (last_plain == r.pre_check);
          if (!e.target_match) all_ok = 1'b0;
        end
        e.all_files_match = all_ok;
        if (r.last_flag && r.last_file) all_ok = 1'b1;
        last_plain = plain;
        owed_q.push_back(e);
      end
    endfunction

    // Compares an accepted result with the oldest one owed.
    function void check_result(input check_res_t got);
      check_res_t e;
      if (owed_q.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("ERROR: unexpected result plain=%h done=%b tm=%b pm=%b all=%b",
                   got.plain_byte, got.header_done, got.target_match,
                   got.pre_match, got.all_files_match);
        mismatches++;
        return;
      end
      e = owed_q.pop_front();
      if (got.plain_byte !== e.plain_byte || got.header_done !== e.header_done ||
          got.target_match !== e.target_match || got.pre_match !== e.pre_match ||
          got.all_files_match !== e.all_files_match) begin
        if (mismatches < REPORT_MAX)
          $display("ERROR: plain=%h/%h done=%b/%b tm=%b/%b pm=%b/%b all=%b/%b (exp/act)",
                   e.plain_byte, got.plain_byte, e.header_done, got.header_done,
                   e.target_match, got.target_match, e.pre_match, got.pre_match,
                   e.all_files_match, got.all_files_match);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   src_idle_pct;
  int   snk_idle_pct;
  int   accepted;
  int   cycles;

  header_check_scoreboard sb;

  zcpc_in_if  req_if ();
  zcpc_out_if res_if ();

  zipcrypto_password_checker_unit dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_if),
    .result  (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("zipcrypto_password_checker_unit verification failed");
      $finish;
    end
  end

  // Result side stalls at random, changing ready on the falling edge.
  always @(negedge clk) begin
    if (rst) res_if.ready <= 1'b0;
    else res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Every accepted result is checked on the rising edge.
  always @(posedge clk) begin : result_monitor
    check_res_t got;
    if (!rst && res_if.valid && res_if.ready) begin
      got.plain_byte      = res_if.plain_byte;
      got.header_done     = res_if.header_done;
      got.target_match    = res_if.target_match;
      got.pre_match       = res_if.pre_match;
      got.all_files_match = res_if.all_files_match;
      sb.check_result(got);
    end
  end

  // Drives one item from a falling edge and waits until it is accepted.
  task automatic send_item(input check_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.cmd          <= r.cmd;
    req_if.data_byte    <= r.data_byte;
    req_if.first_flag   <= r.first_flag;
    req_if.last_flag    <= r.last_flag;
    req_if.last_file    <= r.last_file;
    req_if.target_check <= r.target_check;
    req_if.pre_check    <= r.pre_check;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_item(r);
    accepted++;
    @(negedge clk);
  endtask

  function automatic check_req_t noise_item();
    check_req_t r;
    r.cmd          = 1'($urandom_range(1));
    r.data_byte    = 8'($urandom_range(255));
    r.first_flag   = 1'($urandom_range(1));
    r.last_flag    = 1'($urandom_range(1));
    r.last_file    = 1'($urandom_range(1));
    r.target_check = 8'($urandom_range(255));
    r.pre_check    = 8'($urandom_range(255));
    return r;
  endfunction

  // Password byte; the fields the block ignores carry random values.
  task automatic send_pw(input logic [7:0] ch, input bit starts);
    check_req_t r;
    r            = noise_item();
    r.cmd        = CMD_PASSWORD;
    r.data_byte  = ch;
    r.first_flag = starts;
    send_item(r);
  endtask

  // Encrypts a header of random plaintext under the current password keys.
  // The check bytes either agree with the plaintext or are random.
  task automatic send_header(input int len, input bit is_final, input bit hit_target,
                             input bit hit_pre);
    check_req_t r;
    logic [7:0] plain;
    for (int i = 0; i < len; i++) begin
      plain          = 8'($urandom_range(255));
      r.cmd          = CMD_HEADER;
      r.first_flag   = (i == 0);
      r.last_flag    = (i == len - 1);
      r.last_file    = is_final;
      r.data_byte    = plain ^ sb.next_stream(i == 0);
      r.target_check = (r.last_flag && hit_target) ? plain : 8'($urandom_range(255));
      r.pre_check    = hit_pre ? sb.last_plain : 8'($urandom_range(255));
      send_item(r);
    end
  endtask

  // One candidate password followed by the headers of a set of files.
  task automatic run_candidate();
    int pw_len;
    int n_files;
    int hdr_len;
    pw_len  = $urandom_range(1, 8);
    n_files = $urandom_range(1, 3);
    for (int i = 0; i < pw_len; i++) send_pw(8'($urandom_range(255)), i == 0);
    for (int f = 0; f < n_files; f++) begin
      hdr_len = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : 12;
      send_header(hdr_len, f == n_files - 1, $urandom_range(9) < 8, $urandom_range(9) < 7);
    end
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
  endtask

  initial begin
    sb                  = new();
    rst                 = 1'b1;
    cycles              = 0;
    accepted            = 0;
    src_idle_pct        = IDLE_PCT;
    snk_idle_pct        = IDLE_PCT;
    res_if.ready        = 1'b0;
    req_if.valid        = 1'b0;
    req_if.cmd          = CMD_PASSWORD;
    req_if.data_byte    = 8'h00;
    req_if.first_flag   = 1'b0;
    req_if.last_flag    = 1'b0;
    req_if.last_file    = 1'b0;
    req_if.target_check = 8'h00;
    req_if.pre_check    = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Header byte with no password and no file start: zero working keys.
    send_item('{CMD_HEADER, 8'hFF, 1'b0, 1'b1, 1'b1, 8'h00, 8'h00});
    send_pw(8'h00, 1'b1);
    send_pw(8'hFF, 1'b0);
    send_pw(8'h5A, 1'b0);
    send_header(4, 1'b0, 1'b1, 1'b1);
    // A one-byte header that misses clears the all-files flag.
    send_header(1, 1'b0, 1'b0, 1'b1);
    // The flag stays cleared through a match, then the final file re-arms it.
    send_header(3, 1'b0, 1'b1, 1'b1);
    send_header(2, 1'b1, 1'b1, 1'b0);
    send_header(1, 1'b0, 1'b0, 1'b0);
    // Continuation byte without a file start, then a fresh candidate re-arms.
    send_item('{CMD_HEADER, 8'h00, 1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF});
    send_pw(8'h41, 1'b1);
    send_header(3, 1'b1, 1'b1, 1'b1);
    drain();

    // Random part: mostly well-formed candidates, some noise, with a calm stretch.
    accepted = 0;
    while (accepted < RANDOM_ITEMS) begin
      if (accepted > 220 && accepted < 360) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else begin
        src_idle_pct = IDLE_PCT;
        snk_idle_pct = IDLE_PCT;
      end
      if ($urandom_range(99) < 75) run_candidate();
      else repeat ($urandom_range(1, 4)) send_item(noise_item());
      if ($urandom_range(29) == 0) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("zipcrypto_password_checker_unit verification clean");
    end else begin
      $display("zipcrypto_password_checker_unit verification failed");
    end
    $finish;
  end

endmodule
